// File: hw/rtl/sps_pkg.sv
package sps_pkg;

	localparam int CtxEntries = 256;
	localparam int CtxIdxW = $clog2(CtxEntries);
	localparam logic [16:0] QOne = 17'd65536;
	localparam logic [17:0] AccMax = 18'd262143;
	localparam logic [17:0] AccFloor = 18'd66;
	localparam logic [15:0] BoostThresh = 16'd6554;

	localparam logic [2:0] RegAlpha = 3'd0;
	localparam logic [2:0] RegMargin = 3'd1;
	localparam logic [2:0] RegInterval = 3'd2;
	localparam logic [2:0] RegBlend = 3'd3;
	localparam logic [2:0] RegEpsStart = 3'd4;
	localparam logic [2:0] RegEpsEnd = 3'd5;
	localparam logic [2:0] RegAnneal = 3'd6;

	localparam logic [1:0] WinA = 2'd0;
	localparam logic [1:0] WinB = 2'd1;
	localparam logic [1:0] WinStride = 2'd2;

	// divider request and reply
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

	function automatic logic [16:0] clip_q(input logic [16:0] v);
		return (v > QOne) ? QOne : v;
	endfunction

endpackage

// File: hw/rtl/sps_divider.sv
module sps_divider
	import sps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;

	// shift one numerator bit into the partial remainder
	assign rem_sh = {rem_q[31:0], quo_q[63]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// restoring divide, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!rem_sub[32]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule

// File: hw/rtl/sticky_prefetcher_selector.sv
// Sticky prefetcher selector.
// Input stream s_axis_*: one transaction per cache access, carrying pc,
// both sources' prediction counts, cumulative hit totals and random draws.
// Output stream m_axis_*: one result transaction per access with the issuing
// source, the sticky winner and exploration/boost/sample/switch flags.
// cfg_*: register writes (index, data); write only while the block is idle.
// Timing: one access is worked on at a time; s_axis_tready is low from
// acceptance until the result has been taken. A plain access goes from
// ST_IDLE through ST_DIV and ST_SEL to ST_OUT, where the result is valid.
// Interpolating epsilon adds one pass of the shared bit-serial divider
// (64 quotient bits plus launch and finish) in ST_EPS and ST_EPSW.
// A sample access adds one divider pass per source that issued predictions
// and the accuracy update states ST_GACC, ST_BLEND and ST_UPD.
// Reset: config registers return to defaults, counters and accuracies
// clear, and the context table is marked empty by per-entry valid bits.
// When the receiver stalls, the result holds on m_axis_tdata until taken.
module sticky_prefetcher_selector
	import sps_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pc[63:0], a_pred_count[68:64], b_pred_count[73:69], a_hit_total[105:74],
	// b_hit_total[137:106], rand_explore[153:138], rand_pick[154],
	// rand_boost[170:155], zero fill to 176
	input  logic [175:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// winner[1:0], sticky_choice[2], explored[3], boosted[4], sampled[5],
	// switched[6], zero fill to 8
	output logic [7:0]   m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_EPS   = 10'b00_0000_0010,
		ST_EPSW  = 10'b00_0000_0100,
		ST_DIV   = 10'b00_0000_1000,
		ST_DIVW  = 10'b00_0001_0000,
		ST_GACC  = 10'b00_0010_0000,
		ST_BLEND = 10'b00_0100_0000,
		ST_UPD   = 10'b00_1000_0000,
		ST_SEL   = 10'b01_0000_0000,
		ST_OUT   = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [16:0] alpha_q, blend_q, eps_s_q, eps_e_q;
	logic [17:0] margin_q;
	logic [19:0] interval_q;
	logic [31:0] anneal_q;

	logic [31:0] access_q;
	logic [19:0] samp_cnt_q;
	logic        sticky_q;
	logic [31:0] last_hit_q [2];
	logic [31:0] issued_q [2];
	logic [17:0] gacc_q [2];
	logic [17:0] ctx_mem [CtxEntries][2];
	logic [17:0] ctx_rd_q [2];
	logic [CtxEntries-1:0] ctx_vld_q;

	logic [63:0]  pc_q;
	logic [4:0]   cnt_q [2];
	logic [31:0]  hit_q [2];
	logic [15:0]  rexp_q, rboost_q;
	logic         rpick_q;
	logic         src_q;
	logic         sample_q;
	logic [16:0]  eps_q;
	logic [17:0]  raw_q [2];
	logic [16:0]  bl_q [2];
	logic [7:0]   res_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	sps_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic [CtxIdxW-1:0] ctx_idx;
	assign ctx_idx = pc_q[CtxIdxW:1];

	logic [16:0] eps_s, eps_e, eps_diff;
	assign eps_s = clip_q(eps_s_q);
	assign eps_e = clip_q(eps_e_q);
	assign eps_diff = (eps_s >= eps_e) ? (eps_s - eps_e) : (eps_e - eps_s);

	logic [31:0] delta;
	assign delta = hit_q[src_q] - last_hit_q[src_q];

	// divider launch
	always_comb begin
		div_req.start = 1'b0;
		div_req.num = '0;
		div_req.den = anneal_q;
		if (state_q == ST_EPS) begin
			div_req.start = 1'b1;
			div_req.num = 64'(eps_diff) * 64'(access_q);
		end else if (state_q == ST_DIV) begin
			div_req.start = 1'b1;
			div_req.num = {16'd0, delta, 16'd0};
			div_req.den = issued_q[src_q];
		end
	end

	// sample update arithmetic, both sources side by side, one step per state
	logic [16:0] alpha, blend;
	logic [17:0] gnew [2];
	logic [17:0] cold [2];
	logic [17:0] cnew [2];
	logic [16:0] bl [2];
	logic        sw;
	logic [16:0] inc, chal;
	logic [34:0] gsum [2];
	logic [35:0] csum [2];
	logic [34:0] bsum [2];

	assign alpha = clip_q(alpha_q);
	assign blend = clip_q(blend_q);

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			gsum[i] = 35'(alpha) * 35'(raw_q[i]) + 35'(QOne - alpha) * 35'(gacc_q[i]);
			gnew[i] = (gacc_q[i] == '0) ? raw_q[i] : gsum[i][33:16];
			cold[i] = ctx_vld_q[ctx_idx] ? ctx_rd_q[i] : 18'd0;
			bsum[i] = 35'(blend) * 35'(cold[i]) + 35'(QOne - blend) * 35'(gacc_q[i]);
			bl[i] = (bsum[i][34:16] > 19'(QOne)) ? QOne : bsum[i][32:16];
			csum[i] = 36'(alpha) * 36'(gacc_q[i])
				+ 36'({1'b1, 17'd0} - 18'(alpha)) * 36'(cold[i]);
			cnew[i] = (cold[i] == '0) ? gacc_q[i] : csum[i][34:17];
		end
		inc = bl_q[sticky_q];
		chal = bl_q[~sticky_q];
		sw = ((({19'd0, chal} << 16) > 36'(inc) * 36'(margin_q)) && (18'(chal) >= AccFloor))
			|| ((18'(inc) < AccFloor) && (chal > inc));
	end

	// selection
	logic [1:0] win;
	logic       expl, boost;
	always_comb begin
		expl = 1'b0;
		boost = 1'b0;
		if (cnt_q[0] == '0 && cnt_q[1] == '0) win = WinStride;
		else if (cnt_q[1] == '0) win = WinA;
		else if (cnt_q[0] == '0) win = WinB;
		else begin
			if ({1'b0, rexp_q} < eps_q) begin
				expl = 1'b1;
				win = {1'b0, rpick_q};
			end else win = {1'b0, sticky_q};
			if (rboost_q < BoostThresh) begin
				boost = 1'b1;
				win = {1'b0, ~win[0]};
			end
		end
	end

	logic [19:0] interval;
	logic [19:0] samp_next;
	assign interval = (interval_q == '0) ? 20'd1 : interval_q;
	assign samp_next = samp_cnt_q + 20'd1;

	logic        eps_direct;
	logic [31:0] acc_next;
	assign acc_next = (access_q == '1) ? access_q : access_q + 32'd1;
	assign eps_direct = (anneal_q == '0) || (acc_next >= anneal_q);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = res_q;

	logic [32:0] iss_sum;
	assign iss_sum = 33'(issued_q[win[0]]) + 33'(cnt_q[win[0]]);

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			alpha_q <= 17'd6554;
			margin_q <= 18'd68813;
			interval_q <= 20'd1024;
			blend_q <= 17'd32768;
			eps_s_q <= 17'd32768;
			eps_e_q <= 17'd3277;
			anneal_q <= 32'd100000;
			access_q <= '0;
			samp_cnt_q <= '0;
			sticky_q <= 1'b0;
			last_hit_q[0] <= '0;
			last_hit_q[1] <= '0;
			issued_q[0] <= '0;
			issued_q[1] <= '0;
			gacc_q[0] <= '0;
			gacc_q[1] <= '0;
			ctx_vld_q <= '0;
			src_q <= 1'b0;
			sample_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					RegAlpha:    alpha_q <= cfg_data[16:0];
					RegMargin:   margin_q <= cfg_data[17:0];
					RegInterval: interval_q <= cfg_data[19:0];
					RegBlend:    blend_q <= cfg_data[16:0];
					RegEpsStart: eps_s_q <= cfg_data[16:0];
					RegEpsEnd:   eps_e_q <= cfg_data[16:0];
					RegAnneal:   anneal_q <= cfg_data;
					default:     ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						access_q <= acc_next;
						if (samp_next >= interval) begin
							samp_cnt_q <= '0;
							sample_q <= 1'b1;
						end else begin
							samp_cnt_q <= samp_next;
							sample_q <= 1'b0;
						end
						src_q <= 1'b0;
						state_q <= eps_direct ? ST_DIV : ST_EPS;
					end
				end
				ST_EPS: state_q <= ST_EPSW;
				ST_EPSW: if (div_rsp.done) state_q <= ST_DIV;
				ST_DIV: begin
					if (!sample_q) state_q <= ST_SEL;
					else if (issued_q[src_q] == '0) begin
						if (src_q) state_q <= ST_GACC;
						src_q <= 1'b1;
					end else state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_rsp.done) begin
						src_q <= 1'b1;
						state_q <= src_q ? ST_GACC : ST_DIV;
					end
				end
				ST_GACC: begin
					gacc_q[0] <= gnew[0];
					gacc_q[1] <= gnew[1];
					state_q <= ST_BLEND;
				end
				ST_BLEND: state_q <= ST_UPD;
				ST_UPD: begin
					if (sw) sticky_q <= ~sticky_q;
					ctx_vld_q[ctx_idx] <= 1'b1;
					last_hit_q[0] <= hit_q[0];
					last_hit_q[1] <= hit_q[1];
					issued_q[0] <= '0;
					issued_q[1] <= '0;
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					if (win != WinStride)
						issued_q[win[0]] <= iss_sum[32] ? '1 : iss_sum[31:0];
					state_q <= ST_OUT;
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read the context entry of the held pc
	always_ff @(posedge clk) begin
		ctx_rd_q[0] <= ctx_mem[ctx_idx][0];
		ctx_rd_q[1] <= ctx_mem[ctx_idx][1];
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			pc_q <= s_axis_tdata[63:0];
			cnt_q[0] <= s_axis_tdata[68:64];
			cnt_q[1] <= s_axis_tdata[73:69];
			hit_q[0] <= s_axis_tdata[105:74];
			hit_q[1] <= s_axis_tdata[137:106];
			rexp_q <= s_axis_tdata[153:138];
			rpick_q <= s_axis_tdata[154];
			rboost_q <= s_axis_tdata[170:155];
			eps_q <= eps_e;
			raw_q[0] <= '0;
			raw_q[1] <= '0;
			res_q[6] <= 1'b0;
		end
		if (state_q == ST_EPSW && div_rsp.done)
			eps_q <= (eps_s >= eps_e) ? (eps_s - div_rsp.quo[16:0])
				: (eps_s + div_rsp.quo[16:0]);
		if (state_q == ST_DIVW && div_rsp.done)
			raw_q[src_q] <= (div_rsp.quo > 64'(AccMax)) ? AccMax : div_rsp.quo[17:0];
		if (state_q == ST_BLEND) begin
			bl_q[0] <= bl[0];
			bl_q[1] <= bl[1];
		end
		if (state_q == ST_UPD) begin
			ctx_mem[ctx_idx][0] <= cnew[0];
			ctx_mem[ctx_idx][1] <= cnew[1];
			res_q[6] <= sw;
		end
		if (state_q == ST_SEL) begin
			res_q[1:0] <= win;
			res_q[2] <= sticky_q;
			res_q[3] <= expl;
			res_q[4] <= boost;
			res_q[5] <= sample_q;
			res_q[7] <= 1'b0;
		end
	end

endmodule

// File: bench/sps_checker.sv
`timescale 1ns / 1ps

module sps_checker
	import sps_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [175:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [7:0]   m_axis_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           fails,
	output int           pending,
	output int           samples_seen
);

	typedef struct packed {
		logic [1:0] winner;
		logic       sticky_choice;
		logic       explored;
		logic       boosted;
		logic       sampled;
		logic       switched;
	} decision_t;

	// shadow registers
	logic [16:0] alpha_reg;
	logic [17:0] margin_reg;
	logic [19:0] interval_reg;
	logic [16:0] blend_reg;
	logic [16:0] eps_start_reg;
	logic [16:0] eps_end_reg;
	logic [31:0] anneal_reg;

	// selector state
	logic [31:0] access_cnt;
	logic [19:0] window_cnt;
	logic        holder_b;
	logic [31:0] prev_hits [2];
	logic [31:0] issued [2];
	logic [31:0] glob_acc [2];
	logic [31:0] ctx_acc [CtxEntries][2];

	decision_t decisions_due [$];

	function automatic logic [63:0] clamp_one(input logic [63:0] v);
		return (v > QOne) ? 64'(QOne) : v;
	endfunction

	task automatic clear_state();
		alpha_reg = 17'd6554;
		margin_reg = 18'd68813;
		interval_reg = 20'd1024;
		blend_reg = 17'd32768;
		eps_start_reg = 17'd32768;
		eps_end_reg = 17'd3277;
		anneal_reg = 32'd100000;
		access_cnt = '0;
		window_cnt = '0;
		holder_b = 1'b0;
		for (int i = 0; i < 2; i++) begin
			prev_hits[i] = '0;
			issued[i] = '0;
			glob_acc[i] = '0;
		end
		for (int j = 0; j < CtxEntries; j++) begin
			ctx_acc[j][0] = '0;
			ctx_acc[j][1] = '0;
		end
		decisions_due.delete();
	endtask

	// Update accuracies at a window boundary; return whether the holder changed.
	function automatic logic run_sample(input logic [63:0] pc, input logic [31:0] hits [2]);
		logic [63:0] alpha;
		logic [63:0] blend;
		logic [63:0] raw;
		logic [63:0] v;
		logic [63:0] bl [2];
		logic [63:0] inc;
		logic [63:0] chal;
		logic [31:0] delta;
		logic [CtxIdxW-1:0] idx;
		logic sw;
		alpha = clamp_one(64'(alpha_reg));
		blend = clamp_one(64'(blend_reg));
		idx = pc[CtxIdxW:1];
		sw = 1'b0;
		for (int i = 0; i < 2; i++) begin
			delta = hits[i] - prev_hits[i];
			raw = '0;
			if (issued[i] != 0) begin
				raw = ({32'd0, delta} << 16) / 64'(issued[i]);
				if (raw > AccMax)
					raw = 64'(AccMax);
			end
			if (glob_acc[i] == 0)
				glob_acc[i] = raw[31:0];
			else
				glob_acc[i] = 32'((alpha * raw + (64'd65536 - alpha) * 64'(glob_acc[i])) >> 16);
			prev_hits[i] = hits[i];
			issued[i] = '0;
		end
		for (int i = 0; i < 2; i++) begin
			v = (blend * 64'(ctx_acc[idx][i]) + (64'd65536 - blend) * 64'(glob_acc[i])) >> 16;
			bl[i] = clamp_one(v);
		end
		inc = bl[holder_b];
		chal = bl[!holder_b];
		if ((chal << 16) > inc * 64'(margin_reg) && chal >= AccFloor)
			sw = 1'b1;
		else if (inc < AccFloor && chal > inc)
			sw = 1'b1;
		if (sw)
			holder_b = !holder_b;
		for (int i = 0; i < 2; i++) begin
			if (ctx_acc[idx][i] == 0)
				ctx_acc[idx][i] = glob_acc[i];
			else
				ctx_acc[idx][i] = 32'((alpha * 64'(glob_acc[i]) +
					(64'd131072 - alpha) * 64'(ctx_acc[idx][i])) >> 17);
		end
		return sw;
	endfunction

	function automatic logic [63:0] eps_at_access();
		logic [63:0] s;
		logic [63:0] e;
		s = clamp_one(64'(eps_start_reg));
		e = clamp_one(64'(eps_end_reg));
		if (anneal_reg == 0 || access_cnt >= anneal_reg)
			return e;
		if (s >= e)
			return s - ((s - e) * 64'(access_cnt)) / 64'(anneal_reg);
		return s + ((e - s) * 64'(access_cnt)) / 64'(anneal_reg);
	endfunction

	// Work out the decision for one access transaction.
	task automatic predict_access(input logic [175:0] d);
		logic [63:0] pc;
		logic [31:0] cnt [2];
		logic [31:0] hits [2];
		logic [15:0] r_explore;
		logic        r_pick;
		logic [15:0] r_boost;
		logic [19:0] interval;
		logic [32:0] total;
		logic [1:0]  win;
		decision_t   r;
		pc = d[63:0];
		cnt[0] = 32'(d[68:64]);
		cnt[1] = 32'(d[73:69]);
		hits[0] = d[105:74];
		hits[1] = d[137:106];
		r_explore = d[153:138];
		r_pick = d[154];
		r_boost = d[170:155];
		r = '0;
		if (access_cnt != 32'hFFFF_FFFF)
			access_cnt++;
		interval = (interval_reg == 0) ? 20'd1 : interval_reg;
		window_cnt = window_cnt + 20'd1;
		if (window_cnt >= interval) begin
			r.switched = run_sample(pc, hits);
			r.sampled = 1'b1;
			window_cnt = '0;
		end
		if (cnt[0] == 0 && cnt[1] == 0) begin
			win = WinStride;
		end else if (cnt[1] == 0) begin
			win = WinA;
		end else if (cnt[0] == 0) begin
			win = WinB;
		end else begin
			if (64'(r_explore) < eps_at_access()) begin
				r.explored = 1'b1;
				win = r_pick ? WinB : WinA;
			end else begin
				win = holder_b ? WinB : WinA;
			end
			if (r_boost < BoostThresh) begin
				win = (win == WinA) ? WinB : WinA;
				r.boosted = 1'b1;
			end
		end
		if (win != WinStride) begin
			total = 33'(issued[win[0]]) + 33'(cnt[win[0]]);
			issued[win[0]] = total[32] ? 32'hFFFF_FFFF : total[31:0];
		end
		r.winner = win;
		r.sticky_choice = holder_b;
		decisions_due.push_back(r);
	endtask

	// Compare a result transaction with the oldest pending decision.
	task automatic check_result(input logic [7:0] d);
		decision_t e;
		if (decisions_due.size() == 0) begin
			$error("result with no access pending: 0x%02h", d);
			fails++;
			return;
		end
		e = decisions_due.pop_front();
		if (d[1:0] !== e.winner) begin
			$error("winner expected %0d got %0d", e.winner, d[1:0]);
			fails++;
		end
		if (d[2] !== e.sticky_choice) begin
			$error("sticky_choice expected %0d got %0d", e.sticky_choice, d[2]);
			fails++;
		end
		if (d[3] !== e.explored) begin
			$error("explored expected %0d got %0d", e.explored, d[3]);
			fails++;
		end
		if (d[4] !== e.boosted) begin
			$error("boosted expected %0d got %0d", e.boosted, d[4]);
			fails++;
		end
		if (d[5] !== e.sampled) begin
			$error("sampled expected %0d got %0d", e.sampled, d[5]);
			fails++;
		end
		if (d[6] !== e.switched) begin
			$error("switched expected %0d got %0d", e.switched, d[6]);
			fails++;
		end
		if (e.sampled)
			samples_seen++;
	endtask

	// Track register writes, accesses and results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			fails = 0;
			samples_seen = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					RegAlpha:    alpha_reg = cfg_data[16:0];
					RegMargin:   margin_reg = cfg_data[17:0];
					RegInterval: interval_reg = cfg_data[19:0];
					RegBlend:    blend_reg = cfg_data[16:0];
					RegEpsStart: eps_start_reg = cfg_data[16:0];
					RegEpsEnd:   eps_end_reg = cfg_data[16:0];
					RegAnneal:   anneal_reg = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				predict_access(s_axis_tdata);
			pending = decisions_due.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import sps_pkg::*;

	localparam int IdleLimit = 20000;
	localparam int Settle = 250;
	localparam int RandPhases = 8;
	localparam int PhaseItems = 210;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [175:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [7:0]   m_axis_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	int fails;
	int pending;
	int samples_seen;
	int tx_pct = 0;
	int rx_pct = 0;
	int idle_cycles = 0;
	int accesses = 0;
	logic [31:0] hits_a = '0;
	logic [31:0] hits_b = '0;
	logic [63:0] pc_base = '0;

	sticky_prefetcher_selector u_top (.*);

	sps_checker u_chk (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fails, .pending, .samples_seen
	);

	always #5 clk = ~clk;

	// Stall the result side at random.
	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= rx_pct);
	end

	// End the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("timeout: no transaction in %0d cycles", IdleLimit);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [175:0] pack_access(input logic [63:0] pc, input logic [4:0] a_cnt,
			input logic [4:0] b_cnt, input logic [31:0] a_hits, input logic [31:0] b_hits,
			input logic [15:0] r_explore, input logic r_pick, input logic [15:0] r_boost);
		return {5'd0, r_boost, r_pick, r_explore, b_hits, a_hits, b_cnt, a_cnt, pc};
	endfunction

	// Called at a falling edge; returns at a falling edge with cfg_valid still high.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic send_access(input logic [175:0] d);
		while ($urandom_range(99) < tx_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = d;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		accesses++;
	endtask

	// Hold the sender until every decision has come back, then let the block settle.
	task automatic drain();
		s_axis_tvalid = 1'b0;
		cfg_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (Settle) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_q(input int k);
		case (k)
			0: return 32'd0;
			1: return 32'd65536;
			2: return 32'hFFFF_FFFF;
			default: return 32'($urandom_range(65536));
		endcase
	endfunction

	task automatic random_settings();
		logic [31:0] v;
		write_reg(RegAlpha, pick_q($urandom_range(4)));
		case ($urandom_range(3))
			0: v = 32'd0;
			1: v = 32'd262143;
			2: v = 32'd68813;
			default: v = $urandom_range(262143);
		endcase
		write_reg(RegMargin, v);
		case ($urandom_range(5))
			0: v = 32'd0;
			1: v = 32'd1;
			2: v = 32'd1048575;
			default: v = $urandom_range(12, 2);
		endcase
		write_reg(RegInterval, v);
		write_reg(RegBlend, pick_q($urandom_range(4)));
		write_reg(RegEpsStart, pick_q($urandom_range(4)));
		write_reg(RegEpsEnd, pick_q($urandom_range(4)));
		case ($urandom_range(3))
			0: v = 32'd0;
			1: v = 32'hFFFF_FFFF;
			default: v = $urandom_range(400, 1);
		endcase
		write_reg(RegAnneal, v);
		cfg_valid = 1'b0;
	endtask

	// Mostly well-formed accesses: hit totals grow, pcs repeat; the rest is noise.
	task automatic random_access();
		logic [4:0] a_cnt;
		logic [4:0] b_cnt;
		logic [63:0] pc;
		if ($urandom_range(99) < 85) begin
			a_cnt = ($urandom_range(99) < 15) ? 5'd0 : 5'($urandom_range(31, 1));
			b_cnt = ($urandom_range(99) < 15) ? 5'd0 : 5'($urandom_range(31, 1));
			hits_a = hits_a + $urandom_range(40);
			hits_b = hits_b + $urandom_range(40);
			pc = ($urandom_range(99) < 70) ? pc_base + 64'(2 * $urandom_range(7))
				: {$urandom, $urandom};
			send_access(pack_access(pc, a_cnt, b_cnt, hits_a, hits_b,
				16'($urandom), 1'($urandom), 16'($urandom)));
		end else begin
			send_access(pack_access({$urandom, $urandom}, 5'($urandom), 5'($urandom),
				$urandom, $urandom, 16'($urandom), 1'($urandom), 16'($urandom)));
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: sample every access, flat epsilon, eager switching.
		write_reg(RegAlpha, 32'h0001_FFFF);
		write_reg(RegMargin, 32'd0);
		write_reg(RegInterval, 32'd0);
		write_reg(RegBlend, 32'd0);
		write_reg(RegEpsStart, 32'd65536);
		write_reg(RegEpsEnd, 32'd32768);
		write_reg(RegAnneal, 32'd0);
		write_reg(3'd7, 32'hFFFF_FFFF);
		cfg_valid = 1'b0;
		send_access(pack_access(64'd0, 5'd0, 5'd0, 32'd0, 32'd0, 16'd0, 1'b0, 16'd0));
		send_access(pack_access(64'd2, 5'd31, 5'd0, 32'd0, 32'd0, 16'd0, 1'b1, 16'd0));
		send_access(pack_access(64'd2, 5'd0, 5'd31, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0, 16'd0));
		send_access(pack_access(64'd4, 5'd31, 5'd31, 32'd4, 32'd31, 16'd0, 1'b0, 16'hFFFF));
		send_access(pack_access(64'd4, 5'd1, 5'd1, 32'd5, 32'd40, 16'd0, 1'b1, 16'hFFFF));
		send_access(pack_access(64'd6, 5'd3, 5'd3, 32'd5, 32'd41, 16'hFFFF, 1'b0, 16'd0));
		send_access(pack_access(64'd6, 5'd3, 5'd3, 32'd9, 32'd41, 16'hFFFF, 1'b1, 16'd6553));
		send_access(pack_access(64'd6, 5'd2, 5'd2, 32'd9, 32'd60, 16'hFFFF, 1'b0, 16'd6554));
		send_access(pack_access(64'hFFFF_FFFF_FFFF_FFFF, 5'd1, 5'd1, 32'hFFFF_FFF0,
			32'd60, 16'd32767, 1'b1, 16'd100));
		send_access(pack_access(64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 5'd1, 32'd3,
			32'hFFFF_FFFF, 16'd32768, 1'b0, 16'hFFFF));
		send_access(pack_access(64'h5555_5555_5555_5555, 5'd7, 5'd9, 32'd3, 32'd2,
			16'd0, 1'b1, 16'hFFFF));
		send_access(pack_access(64'hAAAA_AAAA_AAAA_AAAA, 5'd7, 5'd9, 32'd500, 32'd2,
			16'hFFFF, 1'b0, 16'hFFFF));
		send_access(pack_access(64'd0, 5'd0, 5'd0, 32'd500, 32'd2, 16'hFFFF, 1'b1, 16'hFFFF));
		drain();
		write_reg(RegMargin, 32'h0003_FFFF);
		write_reg(RegBlend, 32'd65536);
		write_reg(RegEpsStart, 32'd0);
		write_reg(RegEpsEnd, 32'h0001_FFFF);
		write_reg(RegAnneal, 32'd4);
		cfg_valid = 1'b0;
		for (int i = 0; i < 8; i++)
			send_access(pack_access(64'd8, 5'd31, 5'd31, 32'(100 * i), 32'(i),
				16'(i * 9000), 1'(i), 16'hFFFF));

		// Random phases across settings and idle modes.
		for (int ph = 0; ph < RandPhases; ph++) begin
			drain();
			random_settings();
			case (ph % 4)
				0: begin tx_pct = 0;  rx_pct = 0;  end
				1: begin tx_pct = 60; rx_pct = 0;  end
				2: begin tx_pct = 0;  rx_pct = 60; end
				default: begin tx_pct = 30; rx_pct = 30; end
			endcase
			pc_base = {$urandom, $urandom};
			if ($urandom_range(1)) begin
				hits_a = 32'hFFFF_FF00;
				hits_b = 32'hFFFF_FFC0;
			end
			for (int i = 0; i < PhaseItems; i++)
				random_access();
		end

		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (Settle) @(negedge clk);
		$display("Ran %0d accesses (%0d window samples) over %0d register settings,",
			accesses, samples_seen, RandPhases + 2);
		$display("with free-running, sender-idle, receiver-stall and mixed handshakes.");
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
